[rtl/lca_pkg.sv]
package lca_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int MAX_CLASSES  = 16;

  localparam int FEAT_W  = $clog2(MAX_FEATURES);
  localparam int CLS_W   = $clog2(MAX_CLASSES);
  localparam int NF_W    = 7;
  localparam int NC_W    = 5;
  localparam int WADDR_W = CLS_W + FEAT_W;
  localparam int VAL_W   = 16;
  localparam int BIAS_W  = 32;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + FEAT_W;
  localparam int TOTAL_W = ACC_W + 2;

  localparam logic [1:0] REQ_WEIGHT  = 2'd0;
  localparam logic [1:0] REQ_BIAS    = 2'd1;
  localparam logic [1:0] REQ_FEATURE = 2'd2;

  localparam logic [1:0] REG_FEATURE_COUNT = 2'd0;
  localparam logic [1:0] REG_CLASS_COUNT   = 2'd1;
  localparam logic [1:0] REG_BIAS_ENABLE   = 2'd2;

  localparam logic [NF_W-1:0] FEATURE_COUNT_RST = 7'd64;
  localparam logic [NC_W-1:0] CLASS_COUNT_RST   = 5'd16;

  localparam logic [4:0] NO_CLASS = 5'h1F;

  typedef struct packed {
    logic                     we_weight;
    logic                     we_bias;
    logic                     we_feat;
    logic [CLS_W-1:0]         cls;
    logic [FEAT_W-1:0]        feat;
    logic signed [VAL_W-1:0]  weight;
    logic signed [BIAS_W-1:0] bias;
    logic signed [VAL_W-1:0]  featv;
  } lca_wr_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              zero;
    logic [CLS_W-1:0]  cls;
    logic [FEAT_W-1:0] feat;
  } lca_iss_t;

  typedef struct packed {
    logic             busy;
    logic [CLS_W-1:0] best_cls;
  } lca_stat_t;

endpackage

[rtl/lca_engine.sv]
module lca_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  lca_pkg::lca_wr_t   wr,
  input  lca_pkg::lca_iss_t  iss,
  input  logic               start,
  input  logic               bias_en,
  output lca_pkg::lca_stat_t stat
);

  localparam int DEPTH_W = lca_pkg::MAX_CLASSES * lca_pkg::MAX_FEATURES;

  logic signed [lca_pkg::VAL_W-1:0]  weight_mem [DEPTH_W];
  logic signed [lca_pkg::BIAS_W-1:0] bias_mem   [lca_pkg::MAX_CLASSES];
  logic signed [lca_pkg::VAL_W-1:0]  feat_mem   [lca_pkg::MAX_FEATURES];

  logic signed [lca_pkg::VAL_W-1:0]  w_q_r;
  logic signed [lca_pkg::VAL_W-1:0]  f_q_r;
  logic signed [lca_pkg::BIAS_W-1:0] bias_q_r;

  // stage 1: memory data
  logic                       v1_r, last1_r, zero1_r;
  logic [lca_pkg::CLS_W-1:0]  cls1_r;
  // stage 2: product
  logic                              v2_r, last2_r;
  logic [lca_pkg::CLS_W-1:0]         cls2_r;
  logic signed [lca_pkg::PROD_W-1:0] prod_r;
  logic signed [lca_pkg::PROD_W-1:0] prod_nxt;
  // stage 3: dot product per class
  logic signed [lca_pkg::ACC_W-1:0] acc_r;
  logic signed [lca_pkg::ACC_W-1:0] acc_sum;
  logic signed [lca_pkg::ACC_W-1:0] sum_r;
  logic                             v3_r;
  logic [lca_pkg::CLS_W-1:0]        cls3_r;
  // stage 4: score
  logic signed [lca_pkg::TOTAL_W-1:0] total_r;
  logic signed [lca_pkg::TOTAL_W-1:0] total_nxt;
  logic signed [lca_pkg::BIAS_W-1:0]  bias_add;
  logic                               v4_r;
  logic [lca_pkg::CLS_W-1:0]          cls4_r;
  // stage 5: running best
  logic signed [lca_pkg::TOTAL_W-1:0] best_score_r;
  logic                               best_valid_r;
  logic [lca_pkg::CLS_W-1:0]          best_cls_r;

  always_ff @(posedge clk) begin
    if (wr.we_weight) begin
      weight_mem[{wr.cls, wr.feat}] <= wr.weight;
    end
    w_q_r <= weight_mem[{iss.cls, iss.feat}];
  end

  always_ff @(posedge clk) begin
    if (wr.we_feat) begin
      feat_mem[wr.feat] <= wr.featv;
    end
    f_q_r <= feat_mem[iss.feat];
  end

  always_ff @(posedge clk) begin
    if (wr.we_bias) begin
      bias_mem[wr.cls] <= wr.bias;
    end
    bias_q_r <= bias_mem[cls2_r];
  end

  always_comb begin
    prod_nxt = f_q_r * w_q_r;
    if (zero1_r) begin
      prod_nxt = '0;
    end
    acc_sum   = acc_r + lca_pkg::ACC_W'(prod_r);
    bias_add  = bias_en ? bias_q_r : '0;
    total_nxt = (lca_pkg::TOTAL_W'(sum_r) <<< 1) + lca_pkg::TOTAL_W'(bias_add);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      acc_r        <= '0;
      best_valid_r <= 1'b0;
    end else begin
      v1_r <= iss.valid;
      v2_r <= v1_r;
      v3_r <= v2_r && last2_r;
      v4_r <= v3_r;
      if (v2_r) begin
        acc_r <= last2_r ? '0 : acc_sum;
      end
      if (start) begin
        best_valid_r <= 1'b0;
      end else if (v4_r && (!best_valid_r || total_r > best_score_r)) begin
        best_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    last1_r <= iss.last;
    zero1_r <= iss.zero;
    cls1_r  <= iss.cls;
    last2_r <= last1_r;
    cls2_r  <= cls1_r;
    prod_r  <= prod_nxt;
    sum_r   <= acc_sum;
    cls3_r  <= cls2_r;
    total_r <= total_nxt;
    cls4_r  <= cls3_r;
    if (v4_r && (!best_valid_r || total_r > best_score_r)) begin
      best_score_r <= total_r;
      best_cls_r   <= cls4_r;
    end
  end

  assign stat.busy     = v1_r | v2_r | v3_r | v4_r;
  assign stat.best_cls = best_cls_r;

endmodule

[rtl/linear_classifier_argmax_q15.sv]
// channel  | ports                           | beat
// input    | in_valid / in_ready             | weight load, bias load or feature sample
// result   | out_valid / out_ready           | winning class, -1 when no class
// config   | psel penable pwrite paddr pwdata | feature_count, class_count, bias_enable
//
// loads and non-final samples write their memory and keep the input open
// a final sample starts a prediction, one feature per class per cycle
// through the shared multiply-accumulate pipeline reading weight and feature memories
// synchronous active-low reset restores the register defaults, memories keep no reset
// input stalls while a prediction runs and until its result enters the output register
module linear_classifier_argmax_q15 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [3:0]                        in_class_sel,
  input  logic [5:0]                        in_feature_sel,
  input  logic signed [15:0]                in_weight_value,
  input  logic signed [31:0]                in_bias_value,
  input  logic signed [15:0]                in_feature_value,
  input  logic                              in_last_feature,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [4:0]                 out_win_class,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  logic [lca_pkg::NF_W-1:0] feature_count_r;
  logic [lca_pkg::NC_W-1:0] class_count_r;
  logic                     bias_enable_r;

  logic [lca_pkg::NF_W-1:0]   nf_eff;
  logic [lca_pkg::NC_W-1:0]   nc_eff;
  logic [lca_pkg::FEAT_W-1:0] nf_last;
  logic [lca_pkg::CLS_W-1:0]  nc_last;
  logic                       nf_zero;

  logic [lca_pkg::CLS_W-1:0]  c_r, c_nxt;
  logic [lca_pkg::FEAT_W-1:0] i_r, i_nxt;
  logic [4:0]                 res_r, res_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [4:0]                 out_class_r, out_class_nxt;

  logic in_acc, start, cfg_wr, out_free;

  lca_pkg::lca_wr_t   wr;
  lca_pkg::lca_iss_t  iss;
  lca_pkg::lca_stat_t stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && (in_req_type == lca_pkg::REQ_FEATURE) && in_last_feature;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    nf_eff  = (feature_count_r > lca_pkg::NF_W'(lca_pkg::MAX_FEATURES)) ?
              lca_pkg::NF_W'(lca_pkg::MAX_FEATURES) : feature_count_r;
    nc_eff  = (class_count_r > lca_pkg::NC_W'(lca_pkg::MAX_CLASSES)) ?
              lca_pkg::NC_W'(lca_pkg::MAX_CLASSES) : class_count_r;
    nf_zero = (nf_eff == '0);
    nf_last = nf_zero ? '0 : lca_pkg::FEAT_W'(nf_eff - 1'b1);
    nc_last = lca_pkg::CLS_W'(nc_eff - 1'b1);
  end

  always_comb begin
    wr.we_weight = in_acc && (in_req_type == lca_pkg::REQ_WEIGHT);
    wr.we_bias   = in_acc && (in_req_type == lca_pkg::REQ_BIAS);
    wr.we_feat   = in_acc && (in_req_type == lca_pkg::REQ_FEATURE);
    wr.cls       = in_class_sel;
    wr.feat      = in_feature_sel;
    wr.weight    = in_weight_value;
    wr.bias      = in_bias_value;
    wr.featv     = in_feature_value;
  end

  always_comb begin
    iss.valid = (state_r == S_RUN);
    iss.last  = (i_r == nf_last);
    iss.zero  = nf_zero;
    iss.cls   = c_r;
    iss.feat  = i_r;
  end

  lca_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .iss     (iss),
    .start   (start),
    .bias_en (bias_enable_r),
    .stat    (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    c_nxt         = c_r;
    i_nxt         = i_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_class_nxt = out_class_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          c_nxt = '0;
          i_nxt = '0;
          if (nc_eff == '0) begin
            res_nxt   = lca_pkg::NO_CLASS;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (i_r == nf_last) begin
          i_nxt = '0;
          if (c_r == nc_last) begin
            state_nxt = S_DRAIN;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          res_nxt   = {1'b0, stat.best_cls};
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      c_r             <= '0;
      i_r             <= '0;
      feature_count_r <= lca_pkg::FEATURE_COUNT_RST;
      class_count_r   <= lca_pkg::CLASS_COUNT_RST;
      bias_enable_r   <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      c_r         <= c_nxt;
      i_r         <= i_nxt;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          lca_pkg::REG_FEATURE_COUNT: feature_count_r <= pwdata[lca_pkg::NF_W-1:0];
          lca_pkg::REG_CLASS_COUNT:   class_count_r   <= pwdata[lca_pkg::NC_W-1:0];
          lca_pkg::REG_BIAS_ENABLE:   bias_enable_r   <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    out_class_r <= out_class_nxt;
  end

  always_comb begin
    unique case (paddr[3:2])
      lca_pkg::REG_FEATURE_COUNT: prdata = 32'(feature_count_r);
      lca_pkg::REG_CLASS_COUNT:   prdata = 32'(class_count_r);
      lca_pkg::REG_BIAS_ENABLE:   prdata = 32'(bias_enable_r);
      default:                    prdata = '0;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_win_class = out_class_r;

endmodule

[rtl/lca_chk.sv]
module lca_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_req_type,
  input logic              in_last_feature,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [4:0] out_win_class,
  input logic              pready
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_win_class))
    else $error("result changed while stalled");

  // winner is a class index or the no-class code
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_win_class[4] || out_win_class == 5'h1F))
    else $error("winning class out of range");

  // a final sample blocks the input while scoring
  a_final_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_req_type == lca_pkg::REQ_FEATURE && in_last_feature
    |=> !in_ready)
    else $error("input accepted during scoring");

  // loads keep the input open
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == lca_pkg::REQ_WEIGHT ||
    in_req_type == lca_pkg::REQ_BIAS) |=> in_ready)
    else $error("input stalled after a load");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind linear_classifier_argmax_q15 lca_chk u_lca_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_req_type     (in_req_type),
  .in_last_feature (in_last_feature),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_win_class   (out_win_class),
  .pready          (pready)
);
